// ===== rtl/core/sipq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_pkg: shared types and helpers for the sorted insert priority queue
// Holds the sizing constants, opcode and status codes, the controller state
// type, the command/status structs and the ring and sign helpers.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_FRONT_RD,
        S_FRONT_CAP
    } state_t;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;      // capture the request
        logic exec;       // perform append, pop, clear or start insert
        logic ins_rd;     // read the entry ahead of the insert position
        logic ins_shift;  // move that entry back one slot
        logic ins_put;    // write the new value at the insert position
        logic load_out;   // capture front entry and load the result register
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic ins_scan;   // insert needs a scan of live entries
        logic greater;    // entry read is greater than the new value
        logic pos_one;    // insert position is one behind the front
        logic out_free;   // result register can take a new result
    } dp_stat_t;

    // ring position of a logical offset from the head
    function automatic idx_t slot_of(input idx_t head, input idx_t logical);
        logic [IDX_W:0] s;
        s = {1'b0, head} + {1'b0, logical};
        if (s >= (IDX_W+1)'(DEPTH))
            s = s - (IDX_W+1)'(DEPTH);
        return s[IDX_W-1:0];
    endfunction

    // 32-bit request value to stored width
    function automatic data_t to_store(input logic [31:0] x);
        logic signed [63:0] s;
        s = 64'(signed'(x));
        return s[DATA_WIDTH-1:0];
    endfunction

    // stored value to 32-bit result field
    function automatic logic [31:0] to_out32(input data_t v);
        logic signed [63:0] s;
        s = 64'(signed'(v));
        return s[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sipq_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_ifs: request and result channels of the priority queue
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
interface sipq_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] item_value;

    modport source (output valid, output opcode, output item_value, input ready);
    modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface sipq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] popped_value;
    logic signed [31:0] front_value;
    logic [7:0]         entry_count;
    logic [1:0]         status;

    modport source (output valid, output popped_value, output front_value,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input popped_value, input front_value,
                    input entry_count, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sipq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_ctrl: sequencing controller
// Walks one request through execute, the insert scan and the front read.
// ----------------------------------------------------------------------------
module sipq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire sipq_pkg::dp_stat_t stat,
    output sipq_pkg::dp_cmd_t      cmd
);
    import sipq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.ins_scan ? S_INS_RD : S_FRONT_RD;
            end
            S_INS_RD:
            begin
                cmd.ins_rd = 1'b1;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (stat.greater)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = stat.pos_one ? S_INS_PUT : S_INS_RD;
                end
                else
                    state_next = S_INS_PUT;
            end
            S_INS_PUT:
            begin
                cmd.ins_put = 1'b1;
                state_next  = S_FRONT_RD;
            end
            S_FRONT_RD:
                state_next = S_FRONT_CAP;
            S_FRONT_CAP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/sipq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_dp: queue datapath
// Ring memory, head and count registers, insert position and result register.
// ----------------------------------------------------------------------------
module sipq_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sipq_pkg::dp_cmd_t  cmd,
    output sipq_pkg::dp_stat_t      stat,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [31:0] item_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      popped_value,
    output logic signed [31:0]      front_value,
    output logic [7:0]              entry_count,
    output logic [1:0]              status
);
    import sipq_pkg::*;

    data_t mem [DEPTH];
    data_t rd_data_reg;

    op_t     op_reg;
    data_t   val_reg;
    idx_t    head_reg,  head_next;
    cnt_t    occ_reg,   occ_next;
    idx_t    pos_reg,   pos_next;
    data_t   popped_reg, popped_next;
    status_t st_reg,    st_next;
    data_t   front_cache_reg;

    logic        out_valid_reg;
    logic [31:0] out_popped_reg;
    logic [31:0] out_front_reg;
    cnt_t        out_cnt_reg;
    status_t     out_st_reg;

    logic  full;
    logic  empty;
    idx_t  pos_minus;
    logic  mem_we;
    idx_t  mem_wa;
    data_t mem_wd;
    idx_t  mem_ra;

    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign pos_minus = pos_reg - idx_t'(1);

    assign stat.ins_scan = (op_reg == OP_INSERT) && !full && !empty;
    assign stat.greater  = $signed(rd_data_reg) > $signed(val_reg);
    assign stat.pos_one  = (pos_reg == idx_t'(1));
    assign stat.out_free = !out_valid_reg || out_ready;

    // operation and memory port control
    always_comb
    begin
        head_next   = head_reg;
        occ_next    = occ_reg;
        pos_next    = pos_reg;
        popped_next = popped_reg;
        st_next     = st_reg;
        mem_we      = 1'b0;
        mem_wa      = slot_of(head_reg, pos_reg);
        mem_wd      = val_reg;
        mem_ra      = cmd.ins_rd ? slot_of(head_reg, pos_minus) : head_reg;

        if (cmd.exec)
        begin
            popped_next = '0;
            st_next     = ST_DONE;
            unique case (op_reg)
                OP_APPEND, OP_INSERT:
                begin
                    if (full)
                        st_next = ST_FULL;
                    else
                    begin
                        pos_next = occ_reg[IDX_W-1:0];
                        // append, or an insert into an empty queue, lands at the back
                        if (op_reg == OP_APPEND || empty)
                        begin
                            mem_we   = 1'b1;
                            mem_wa   = slot_of(head_reg, occ_reg[IDX_W-1:0]);
                            occ_next = occ_reg + cnt_t'(1);
                        end
                    end
                end
                OP_POP:
                begin
                    if (empty)
                        st_next = ST_EMPTY;
                    else
                    begin
                        popped_next = front_cache_reg;
                        head_next   = slot_of(head_reg, idx_t'(1));
                        occ_next    = occ_reg - cnt_t'(1);
                    end
                end
                OP_CLEAR:
                begin
                    head_next = '0;
                    occ_next  = '0;
                end
            endcase
        end
        else if (cmd.ins_shift)
        begin
            mem_we   = 1'b1;
            mem_wd   = rd_data_reg;
            pos_next = pos_minus;
        end
        else if (cmd.ins_put)
        begin
            mem_we   = 1'b1;
            occ_next = occ_reg + cnt_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= op_t'(opcode);
            val_reg <= to_store(item_value);
        end
        pos_reg    <= pos_next;
        popped_reg <= popped_next;
        st_reg     <= st_next;
        if (cmd.load_out)
        begin
            front_cache_reg <= rd_data_reg;
            out_popped_reg  <= to_out32(popped_reg);
            out_front_reg   <= empty ? 32'd0 : to_out32(rd_data_reg);
            out_cnt_reg     <= occ_reg;
            out_st_reg      <= st_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = signed'(out_popped_reg);
    assign front_value  = signed'(out_front_reg);
    assign entry_count  = 8'(out_cnt_reg);
    assign status       = out_st_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && op_reg == OP_POP && !empty |=> occ_reg == $past(occ_reg) - cnt_t'(1))
        else $error("pop did not drop the count by one");

    a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_shift |-> pos_reg != '0)
        else $error("shift past the front");

    a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_put |-> !full)
        else $error("insert write into a full queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sorted_insert_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue: bounded ring queue with sorted insert
// Top level; joins the request and result channels to controller and datapath.
// ----------------------------------------------------------------------------
// A request carries an opcode (append at back, sorted insert, pop front, clear)
// and a signed value; each request gives exactly one result with the popped
// value, the new front value, the entry count and a status (done, full so the
// push was dropped, empty so the pop returned zero). Entries live in a
// single-port-write, registered-read ring memory of DEPTH words. One request
// is in work at a time: append, pop, clear and a full or empty-queue insert go
// through execute and the front read to the result; a sorted insert also scans
// from the back, moving entries back one slot until it meets a smaller or
// equal entry or reaches the front, each step of the scan being a memory read
// followed by a compare and write on the same memory. A new request is taken
// while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue (
    input wire logic  clk,
    input wire logic  rst_n,
    sipq_req_if.sink  req,
    sipq_rsp_if.source rsp
);
    import sipq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing of one request at a time
    sipq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // ring memory, pointers and result register
    sipq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (req.opcode),
        .item_value   (req.item_value),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .popped_value (rsp.popped_value),
        .front_value  (rsp.front_value),
        .entry_count  (rsp.entry_count),
        .status       (rsp.status)
    );

endmodule

`default_nettype wire
